### sv/fph_pkg.sv
`timescale 1ns / 1ps
// fph_pkg: shared constants, types and register codes of the five-point heat stencil
// no dependencies; imported by fph_lines, fph_cell, five_point_heat_stencil and tb_five_point_heat_stencil

package fph_pkg;

  localparam int MaxWidth      = 1024;
  localparam int PointBits     = 32;
  localparam int HeightLimit   = 4096;
  localparam int LineDepth     = MaxWidth + 2;
  localparam int ColBits       = $clog2(LineDepth);
  localparam int RowBits       = $clog2(HeightLimit + 2);
  localparam int WidthRegBits  = 11;
  localparam int HeightRegBits = 13;
  localparam int CfgDataBits   = 13;
  localparam int HeatBits      = 48;
  localparam int SumBits       = PointBits + 2;
  localparam int NumCells      = 2;

  localparam logic [WidthRegBits-1:0]  WidthReset  = WidthRegBits'(64);
  localparam logic [HeightRegBits-1:0] HeightReset = HeightRegBits'(64);

  localparam logic signed [HeatBits-1:0] HeatMax = {1'b0, {(HeatBits-1){1'b1}}};
  localparam logic signed [HeatBits-1:0] HeatMin = {1'b1, {(HeatBits-1){1'b0}}};

  typedef enum logic [0:0] {
    RegBlockWidth  = 1'b0,
    RegBlockHeight = 1'b1
  } cfg_reg_e;

  typedef logic signed [PointBits-1:0] point_t;

  // one grid column of the window: previous-previous row, previous row, current row
  typedef struct packed {
    point_t up;
    point_t mid;
    point_t low;
  } column_t;

  typedef struct packed {
    logic frame_start;
    logic last;
    logic emit;
  } item_ctl_t;

endpackage

### sv/fph_lines.sv
`timescale 1ns / 1ps
// fph_lines: the two line stores (upper and middle rows), one entry per column
// depends on fph_pkg

module fph_lines (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [fph_pkg::ColBits-1:0]  rd_addr_i,
  input  logic                         wr_en_i,
  input  logic [fph_pkg::ColBits-1:0]  wr_addr_i,
  input  fph_pkg::point_t              wr_point_i,
  output fph_pkg::point_t              mid_o,
  output fph_pkg::point_t              up_o
);
  import fph_pkg::*;

  point_t mid_mem [LineDepth];
  point_t up_mem  [LineDepth];
  point_t mid_rd_q;
  point_t up_rd_q;

  // the item being written read its own column earlier; its old middle
  // entry moves up one row while the new point takes its place
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mid_mem[wr_addr_i] <= wr_point_i;
      up_mem[wr_addr_i]  <= mid_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mid_rd_q <= mid_mem[rd_addr_i];
      up_rd_q  <= up_mem[rd_addr_i];
    end
  end

  assign mid_o = mid_rd_q;
  assign up_o  = up_rd_q;

endmodule

### sv/fph_cell.sv
`timescale 1ns / 1ps
// fph_cell: one column cell of the sliding stencil window
// depends on fph_pkg

module fph_cell (
  input  logic             clk_i,
  input  logic             shift_i,
  input  fph_pkg::column_t col_i,
  output fph_pkg::column_t col_o
);
  import fph_pkg::*;

  column_t col_q;

  // take the neighbor's column whenever an item moves through the window
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

### sv/five_point_heat_stencil.sv
`timescale 1ns / 1ps
// Five-point Jacobi heat stencil over one halo-padded grid block. Points of
// (block_width+2) x (block_height+2) signed Q16.16 values stream in raster
// order, halo included, and for each interior point the block returns half
// the old centre plus one eighth of its four old neighbours (arithmetic
// shifts, rounding toward minus infinity), a 48-bit saturating running sum
// of the returned values and a flag on the last interior point. The block
// takes one item per clock cycle unless the output stalls; the item that
// completes a window passes stages b, c and d, then the output register;
// those three internal stages take up to three items while a result waits.
// The rate is set by the line stores: each has one read and one write port,
// and every item uses each exactly once. frame_start restarts the counters
// and the sum; a block that ends on its last halo point needs no
// frame_start before the next one. Widths 0 and above 1024 act as 1 and
// 1024, heights 0 and above 4096 act as 1 and 4096. Line store contents
// are undefined after reset until written by a full row.
// depends on fph_pkg, fph_lines and fph_cell

module five_point_heat_stencil (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  fph_pkg::cfg_reg_e                cfg_index_i,
  input  logic [fph_pkg::CfgDataBits-1:0]  cfg_data_i,
  // grid points in
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [fph_pkg::PointBits-1:0] grid_point_i,
  input  logic                             frame_start_i,
  // updated points out
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [fph_pkg::PointBits-1:0] new_value_o,
  output logic signed [fph_pkg::HeatBits-1:0]  heat_total_o,
  output logic                             last_point_o
);
  import fph_pkg::*;

  // configuration registers
  logic [WidthRegBits-1:0]  block_width_q;
  logic [HeightRegBits-1:0] block_height_q;

  // counters and running sum
  logic [ColBits-1:0]        col_q, col_d;
  logic [RowBits-1:0]        row_q, row_d;
  logic signed [HeatBits-1:0] heat_q, heat_d;

  // stage handshake
  logic o_free, d_free, c_free, b_free;
  logic accept, b_move, c_move, d_move;

  // stage a: position of the incoming point
  logic [ColBits-1:0] width_eff, cur_col;
  logic [RowBits-1:0] height_eff, cur_row;
  logic               row_end, frame_end;
  item_ctl_t          a_ctl;

  // stage b: window assembly
  logic               b_valid_q;
  item_ctl_t          b_ctl_q;
  point_t             b_point_q;
  logic [ColBits-1:0] b_col_q;
  point_t             line_mid, line_up;
  column_t            cell_in  [NumCells];
  column_t            cell_out [NumCells];
  logic signed [SumBits-1:0] b_sum;

  // stage c: neighbour sum done
  logic                      c_valid_q;
  item_ctl_t                 c_ctl_q;
  logic signed [SumBits-1:0] c_sum_q;
  point_t                    c_centre_q;
  point_t                    c_new;

  // stage d: new value done
  logic                        d_valid_q;
  item_ctl_t                   d_ctl_q;
  point_t                      d_new_q;
  logic signed [HeatBits-1:0]  heat_base, heat_sat;
  logic signed [HeatBits:0]    heat_wide;

  // output register
  logic                       out_valid_q;
  point_t                     new_value_q;
  logic signed [HeatBits-1:0] heat_total_q;
  logic                       last_point_q;

  //--------------------------------------------------------------------
  // configuration port, always ready
  //--------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_width_q  <= WidthReset;
      block_height_q <= HeightReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegBlockWidth:  block_width_q  <= cfg_data_i[WidthRegBits-1:0];
        RegBlockHeight: block_height_q <= cfg_data_i[HeightRegBits-1:0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------
  // pipeline flow: each stage moves when the one after it has room
  //--------------------------------------------------------------------
  assign o_free = !out_valid_q || out_ready_i;
  assign d_free = !d_valid_q || o_free;
  assign c_free = !c_valid_q || d_free;
  assign b_free = !b_valid_q || c_free;

  assign accept = in_valid_i && b_free;
  assign b_move = b_valid_q && c_free;
  assign c_move = c_valid_q && d_free;
  assign d_move = d_valid_q && o_free;

  assign in_ready_o = b_free;

  //--------------------------------------------------------------------
  // stage a: clamp the block size, place the point in the block
  //--------------------------------------------------------------------
  always_comb begin
    if (block_width_q == '0) begin
      width_eff = ColBits'(1);
    end else if (int'(block_width_q) > MaxWidth) begin
      width_eff = ColBits'(MaxWidth);
    end else begin
      width_eff = ColBits'(block_width_q);
    end

    if (block_height_q == '0) begin
      height_eff = RowBits'(1);
    end else if (int'(block_height_q) > HeightLimit) begin
      height_eff = RowBits'(HeightLimit);
    end else begin
      height_eff = RowBits'(block_height_q);
    end
  end

  always_comb begin
    // frame start counts the point as the first of a new block
    cur_col   = frame_start_i ? '0 : col_q;
    cur_row   = frame_start_i ? '0 : row_q;
    // a counter at or past the last halo index closes its row or block
    row_end   = cur_col >= (width_eff + ColBits'(1));
    frame_end = row_end && (cur_row >= (height_eff + RowBits'(1)));

    a_ctl.frame_start = frame_start_i;
    a_ctl.last        = frame_end;
    // the point one row down and one column right closes an interior window
    a_ctl.emit        = (cur_row >= RowBits'(2)) && (cur_col >= ColBits'(2));

    if (row_end) begin
      col_d = '0;
      row_d = frame_end ? '0 : cur_row + RowBits'(1);
    end else begin
      col_d = cur_col + ColBits'(1);
      row_d = cur_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  //--------------------------------------------------------------------
  // line stores: the column's two older rows are read as the item enters
  // and rotated as it leaves stage b
  //--------------------------------------------------------------------
  fph_lines u_lines (
    .clk_i      (clk_i),
    .rd_en_i    (accept),
    .rd_addr_i  (cur_col),
    .wr_en_i    (b_move),
    .wr_addr_i  (b_col_q),
    .wr_point_i (b_point_q),
    .mid_o      (line_mid),
    .up_o       (line_up)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_free) begin
      b_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_ctl_q   <= a_ctl;
      b_point_q <= grid_point_i;
      b_col_q   <= cur_col;
    end
  end

  //--------------------------------------------------------------------
  // window cells: cell 0 holds the column left of the current one, cell 1
  // the column before that; the current column comes from the line stores
  //--------------------------------------------------------------------
  always_comb begin
    cell_in[0].up  = line_up;
    cell_in[0].mid = line_mid;
    cell_in[0].low = b_point_q;
    for (int i = 1; i < NumCells; i++) begin
      cell_in[i] = cell_out[i-1];
    end
  end

  for (genvar g = 0; g < NumCells; g++) begin : g_cells
    fph_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (b_move),
      .col_i   (cell_in[g]),
      .col_o   (cell_out[g])
    );
  end

  // north, south and centre from the left column, west two back, east current
  assign b_sum = SumBits'(cell_out[0].up) + SumBits'(cell_out[0].low)
               + SumBits'(cell_out[1].mid) + SumBits'(line_mid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_free) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_move) begin
      c_ctl_q    <= b_ctl_q;
      c_sum_q    <= b_sum;
      c_centre_q <= cell_out[0].mid;
    end
  end

  //--------------------------------------------------------------------
  // stage c: half the centre plus an eighth of the neighbours, floor shifts
  //--------------------------------------------------------------------
  assign c_new = PointBits'(c_centre_q >>> 1) + PointBits'(c_sum_q >>> 3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (d_free) begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_move) begin
      d_ctl_q <= c_ctl_q;
      d_new_q <= c_new;
    end
  end

  //--------------------------------------------------------------------
  // stage d: saturating running sum; every item passes so that frame
  // start clears the sum even on points that give no result
  //--------------------------------------------------------------------
  always_comb begin
    heat_base = d_ctl_q.frame_start ? '0 : heat_q;
    heat_wide = (HeatBits+1)'(heat_base) + (HeatBits+1)'(d_new_q);
    // the two top bits differ only when the sum left the 48-bit range
    if (heat_wide[HeatBits] != heat_wide[HeatBits-1]) begin
      heat_sat = heat_wide[HeatBits] ? HeatMin : HeatMax;
    end else begin
      heat_sat = heat_wide[HeatBits-1:0];
    end

    if (d_ctl_q.last) begin
      heat_d = '0;
    end else if (d_ctl_q.emit) begin
      heat_d = heat_sat;
    end else begin
      heat_d = heat_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heat_q <= '0;
    end else if (d_move) begin
      heat_q <= heat_d;
    end
  end

  //--------------------------------------------------------------------
  // output register
  //--------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (o_free) begin
      out_valid_q <= d_valid_q && d_ctl_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_move) begin
      new_value_q  <= d_new_q;
      heat_total_q <= heat_sat;
      last_point_q <= d_ctl_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign new_value_o  = new_value_q;
  assign heat_total_o = heat_total_q;
  assign last_point_o = last_point_q;

endmodule

### dv/tb_five_point_heat_stencil.sv
`timescale 1ns / 1ps
// tb_five_point_heat_stencil: self-checking bench for the five-point heat stencil,
// random-stall driver and monitor around a cycle-free predictor of the stencil
// depends on fph_pkg and five_point_heat_stencil

module tb_five_point_heat_stencil;
  import fph_pkg::*;

  localparam int CycleLimit  = 5_000_000;
  // at least this many grid points are sent over the whole run, directed and random
  localparam int TotalItems  = 1950;
  // extra wait after the last result is back, so any late output is covered
  localparam int DrainCycles = 8;

  typedef enum int {PatRandom, PatCorner, PatSmall, PatAllMax, PatAllMin} pattern_e;
  typedef enum int {IdleNone, IdleDense, IdleSparse} idle_e;

  typedef struct {
    point_t value;
    logic   start;
  } grid_item_t;

  typedef struct {
    point_t                      value;
    logic signed [HeatBits-1:0]  heat;
    logic                        last;
  } heat_point_t;

  // clock, reset and block ports
  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;
  cfg_reg_e                     cfg_index_i   = RegBlockWidth;
  logic [CfgDataBits-1:0]       cfg_data_i    = '0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_ready_o;
  point_t                       grid_point_i  = '0;
  logic                         frame_start_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i   = 1'b0;
  point_t                       new_value_o;
  logic signed [HeatBits-1:0]   heat_total_o;
  logic                         last_point_o;

  five_point_heat_stencil u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .grid_point_i  (grid_point_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .new_value_o   (new_value_o),
    .heat_total_o  (heat_total_o),
    .last_point_o  (last_point_o)
  );

  // grid points waiting to be driven, and updated points waiting to come out
  grid_item_t  grid_items [$];
  heat_point_t due_points [$];

  int    pushed_n  = 0;
  int    taken_n   = 0;
  int    fail_n    = 0;
  int    cycle_n   = 0;
  int    gap_left  = 0;
  int    stall_left = 0;
  idle_e in_idle_mode  = IdleNone;
  idle_e out_idle_mode = IdleNone;

  // stencil state as the block holds it: sizes, two line stores, counters, sum
  logic [WidthRegBits-1:0]  width_reg  = WidthReset;
  logic [HeightRegBits-1:0] height_reg = HeightReset;
  longint      upper_row  [LineDepth];
  longint      middle_row [LineDepth];
  longint      west_one   = 0;
  longint      west_two   = 0;
  longint      heat_acc   = 0;
  int unsigned col_n      = 0;
  int unsigned row_n      = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int span(int raw, int top);
    if (raw < 1) return 1;
    if (raw > top) return top;
    return raw;
  endfunction

  // one grid point taken: advance the window, queue the updated point if any
  function automatic void predict_stencil(point_t x, logic start);
    int unsigned w, h, c, r;
    bit          row_end, blk_end;
    longint      centre, ring, nv, hs;
    heat_point_t e;
    w = span(int'(width_reg), MaxWidth);
    h = span(int'(height_reg), HeightLimit);
    if (start) begin
      col_n    = 0;
      row_n    = 0;
      heat_acc = 0;
    end
    c = col_n;
    r = row_n;
    row_end = c >= w + 1;
    blk_end = row_end && r >= h + 1;
    if (r >= 2 && c >= 2) begin
      centre = middle_row[c-1];
      ring   = upper_row[c-1] + west_one + middle_row[c-2] + middle_row[c];
      // arithmetic shifts round toward minus infinity
      nv = (centre >>> 1) + (ring >>> 3);
      hs = heat_acc + nv;
      if (hs > longint'(HeatMax)) hs = longint'(HeatMax);
      if (hs < longint'(HeatMin)) hs = longint'(HeatMin);
      heat_acc = hs;
      e.value = nv[PointBits-1:0];
      e.heat  = hs[HeatBits-1:0];
      e.last  = blk_end;
      due_points.push_back(e);
    end
    // line stores trail the window by one column
    if (c >= 1) upper_row[c-1] = middle_row[c-1];
    if (c >= 2) middle_row[c-2] = west_two;
    if (row_end) begin
      upper_row[c] = middle_row[c];
      if (c >= 1) middle_row[c-1] = west_one;
      middle_row[c] = x;
    end
    west_two = west_one;
    west_one = x;
    if (row_end) begin
      col_n = 0;
      if (blk_end) begin
        row_n    = 0;
        heat_acc = 0;
      end else begin
        row_n = r + 1;
      end
    end else begin
      col_n = c + 1;
    end
  endfunction

  function automatic int draw_wait(idle_e mode);
    case (mode)
      IdleDense:  return $urandom_range(0, 19);
      IdleSparse: return ($urandom_range(0, 15) == 0) ? $urandom_range(0, 19) : 0;
      default:    return 0;
    endcase
  endfunction

  function automatic idle_e pick_idle();
    case ($urandom_range(0, 5))
      0:       return IdleNone;
      1:       return IdleSparse;
      default: return IdleDense;
    endcase
  endfunction

  function automatic point_t draw_point(pattern_e pat);
    case (pat)
      PatAllMax: return 32'sh7FFF_FFFF;
      PatAllMin: return 32'sh8000_0000;
      PatSmall:  return point_t'(int'($urandom_range(0, 2097151)) - 1048576);
      PatCorner: begin
        // odd negatives show the rounding of the shifts
        case ($urandom_range(0, 5))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return 32'sh8000_0001;
          3:       return -32'sd1;
          4:       return 32'sd1;
          default: return 32'sd0;
        endcase
      end
      default:   return point_t'($urandom);
    endcase
  endfunction

  // queue a block of w x h interior points with halo, or only its first keep points
  task automatic queue_block(int w, int h, pattern_e pat, bit with_start, int keep);
    int         total;
    grid_item_t it;
    total = (w + 2) * (h + 2);
    if (keep >= 0 && keep < total) total = keep;
    for (int k = 0; k < total; k++) begin
      it.value = draw_point(pat);
      it.start = with_start && (k == 0);
      grid_items.push_back(it);
    end
    pushed_n += total;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataBits-1:0] data);
    bit seen;
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      seen = cfg_ready_o;
      @(posedge clk_i);
    end while (!seen);
    cfg_valid_i <= 1'b0;
    if (idx == RegBlockWidth) width_reg = data[WidthRegBits-1:0];
    else height_reg = data[HeightRegBits-1:0];
  endtask

  // all items taken, all results back, then let the pipeline run dry
  task automatic settle();
    do @(negedge clk_i); while (taken_n != pushed_n || due_points.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic flag_failure(string msg);
    fail_n++;
    if (fail_n <= 10) $display("%s", msg);
  endtask

  // input side: hold each item until taken, then idle for the drawn gap
  always @(posedge clk_i or negedge rst_ni) begin : in_side
    grid_item_t nxt;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      grid_point_i  <= '0;
      frame_start_i <= 1'b0;
      gap_left      <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_stencil(grid_point_i, frame_start_i);
        taken_n++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (grid_items.size() != 0) begin
          nxt = grid_items.pop_front();
          in_valid_i    <= 1'b1;
          grid_point_i  <= nxt.value;
          frame_start_i <= nxt.start;
          gap_left      <= draw_wait(in_idle_mode);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output side: check each result against the oldest expectation, then stall
  always @(posedge clk_i or negedge rst_ni) begin : out_side
    int          wait_n;
    heat_point_t exp_pt;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      wait_n = stall_left;
      if (out_valid_o && out_ready_i) begin
        if (due_points.size() == 0) begin
          flag_failure($sformatf("unexpected result: new_value %0d heat_total %0d last %0b",
                                 new_value_o, heat_total_o, last_point_o));
        end else begin
          exp_pt = due_points.pop_front();
          if (new_value_o !== exp_pt.value || heat_total_o !== exp_pt.heat ||
              last_point_o !== exp_pt.last) begin
            flag_failure($sformatf(
              "mismatch: new_value exp %0d got %0d, heat_total exp %0d got %0d, last exp %0b got %0b",
              exp_pt.value, new_value_o, exp_pt.heat, heat_total_o,
              exp_pt.last, last_point_o));
          end
        end
        wait_n = draw_wait(out_idle_mode);
      end
      if (wait_n != 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= wait_n - 1;
      end else begin
        out_ready_i <= 1'b1;
        stall_left  <= 0;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int                     w, h, nblk, sel;
    logic [CfgDataBits-1:0] wraw, hraw;
    pattern_e               pat;
    bit                     clean;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // width straight out of reset: two full rows of 66 and part of the third
    in_idle_mode  = IdleSparse;
    out_idle_mode = IdleSparse;
    queue_block(64, 64, PatRandom, 1'b1, 2 * 66 + 20);
    settle();

    // height straight out of reset: one-column block down all 66 rows
    in_idle_mode  = IdleDense;
    out_idle_mode = IdleDense;
    write_reg(RegBlockWidth, 13'd1);
    queue_block(1, 64, PatRandom, 1'b1, -1);
    settle();

    // width 0 with ignored upper bits set, height 0: both act as one
    in_idle_mode  = IdleDense;
    out_idle_mode = IdleDense;
    write_reg(RegBlockWidth, 13'h1800);
    write_reg(RegBlockHeight, 13'd0);
    queue_block(1, 1, PatAllMax, 1'b1, -1);
    // block end returns counters to zero, so no frame_start needed
    queue_block(1, 1, PatAllMin, 1'b0, -1);
    // frame_start cutting a block short
    queue_block(1, 1, PatCorner, 1'b1, 3);
    queue_block(1, 1, PatCorner, 1'b1, -1);
    settle();

    // sizes shrink in the middle of a block: row 4 column 7 ends row and block
    write_reg(RegBlockWidth, 13'd8);
    write_reg(RegBlockHeight, 13'd6);
    queue_block(8, 6, PatRandom, 1'b1, 4 * 10 + 7);
    settle();
    write_reg(RegBlockWidth, 13'd3);
    write_reg(RegBlockHeight, 13'd2);
    queue_block(3, 2, PatRandom, 1'b0, 1);
    queue_block(3, 2, PatRandom, 1'b0, -1);
    settle();

    // width above the limit with ignored upper bits set acts as 1024: one full
    // halo row back to back, then narrowed to one column to finish the block
    in_idle_mode  = IdleNone;
    out_idle_mode = IdleSparse;
    write_reg(RegBlockWidth, 13'h1FFF);
    write_reg(RegBlockHeight, 13'd2);
    queue_block(1024, 2, PatCorner, 1'b1, 1026);
    settle();
    write_reg(RegBlockWidth, 13'd1);
    queue_block(1, 2, PatRandom, 1'b0, 9);
    settle();

    // random phases: mostly whole blocks, some cut short, some stray points
    while (pushed_n < TotalItems) begin
      wraw = 13'($urandom_range(0, 12)) | (13'($urandom_range(0, 3)) << 11);
      hraw = 13'($urandom_range(0, 10));
      if ($urandom_range(0, 7) == 0) begin
        wraw = 13'($urandom_range(13, 24));
        hraw = 13'($urandom_range(3, 6));
      end
      write_reg(RegBlockWidth, wraw);
      write_reg(RegBlockHeight, hraw);
      w = span(int'(wraw[WidthRegBits-1:0]), MaxWidth);
      h = span(int'(hraw), HeightLimit);
      in_idle_mode  = pick_idle();
      out_idle_mode = pick_idle();
      clean = 1'b1;
      nblk  = $urandom_range(2, 5);
      for (int b = 0; b < nblk && pushed_n < TotalItems; b++) begin
        sel = $urandom_range(0, 9);
        pat = ($urandom_range(0, 2) != 0) ? PatRandom : pattern_e'($urandom_range(0, 4));
        if (sel < 7) begin
          queue_block(w, h, pat, !clean || $urandom_range(0, 1), -1);
          clean = 1'b1;
        end else if (sel < 9) begin
          queue_block(w, h, pat, 1'b1, $urandom_range(1, (w + 2) * (h + 2) - 1));
          clean = 1'b0;
        end else begin
          repeat ($urandom_range(1, 6)) queue_block(w, h, pat, $urandom_range(0, 1), 1);
          clean = 1'b0;
        end
      end
      // close each phase on a whole block so the counters sit at zero
      queue_block(w, h, PatRandom, 1'b1, -1);
      settle();
    end

    if (fail_n == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
